[sv/mbp_pkg.sv]
// Shared types and constants of the MSB-first bit packer.
package mbp_pkg;

  localparam int WordW  = 32;
  localparam int ByteW  = 8;
  localparam int CountW = 6;
  localparam int FillW  = 3;
  localparam int NbyteW = 3;

  localparam logic [CountW-1:0] MaxCount = 6'd32;

  typedef enum logic [1:0] {
    OP_PACK  = 2'd0,
    OP_RAW   = 2'd1,
    OP_MARK  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  // One job handed from the front end to the back end.
  typedef struct packed {
    logic              is_pack;
    logic              byte_valid;
    logic [WordW-1:0]  word;
    logic [FillW-1:0]  fill;
    logic [NbyteW-1:0] nbytes;
    logic [WordW-1:0]  total;
    logic [WordW-1:0]  since;
  } job_t;

endpackage

[sv/mbp_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface mbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] value;
  logic [5:0]  bit_count;
  logic [5:0]  start_bit;

  modport source (output valid, operation, value, bit_count, start_bit, input ready);
  modport sink (input valid, operation, value, bit_count, start_bit, output ready);
endinterface

interface mbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [31:0] total_bits;
  logic [31:0] bits_since_mark;
  logic        last;

  modport source (output valid, out_byte, byte_valid, total_bits, bits_since_mark, last,
                  input ready);
  modport sink (input valid, out_byte, byte_valid, total_bits, bits_since_mark, last,
                output ready);
endinterface

[sv/mbp_front.sv]
// Front end: accepts items, keeps the counters and fill level, and builds jobs.
module mbp_front (
  input  logic          clk,
  input  logic          rst,
  mbp_in_if.sink        in_item,
  input  logic          q_full,
  output logic          push,
  output mbp_pkg::job_t push_job
);
  import mbp_pkg::*;

  logic [FillW-1:0]    fill_count, fill_count_next;
  logic [WordW-1:0]    bit_total, bit_total_next;
  logic [WordW-1:0]    since_mark, since_mark_next;
  logic [CountW-1:0]   count_sat;
  logic [2*WordW-1:0]  shifted;
  logic [WordW-1:0]    field;
  logic [CountW-1:0]   fill_sum;
  logic                accept;
  op_t                 op;

  assign op            = op_t'(in_item.operation);
  assign in_item.ready = !q_full;
  assign accept        = in_item.valid && in_item.ready;

  always_comb begin
    count_sat = (in_item.bit_count > MaxCount) ? MaxCount : in_item.bit_count;
    // Left-justify the field so that position start_bit lands in bit 31;
    // positions outside the word shift in as zeros.
    shifted = {in_item.value, {WordW{1'b0}}} >> ({1'b0, in_item.start_bit} + 7'd1);
    field   = shifted[WordW-1:0] & ~({WordW{1'b1}} >> count_sat);
    fill_sum = {{(CountW-FillW){1'b0}}, fill_count} + count_sat;

    fill_count_next = fill_count;
    bit_total_next  = bit_total;
    since_mark_next = since_mark;
    push            = 1'b0;

    push_job.is_pack    = 1'b0;
    push_job.byte_valid = 1'b1;
    push_job.word       = field;
    push_job.fill       = fill_count;
    push_job.nbytes     = fill_sum[CountW-1:FillW];

    unique case (op)
      OP_PACK: begin
        fill_count_next  = fill_sum[FillW-1:0];
        bit_total_next   = bit_total + {{(WordW-CountW){1'b0}}, count_sat};
        since_mark_next  = since_mark + {{(WordW-CountW){1'b0}}, count_sat};
        push             = accept;
        push_job.is_pack = 1'b1;
      end
      OP_RAW: begin
        bit_total_next  = bit_total + {{(WordW-CountW){1'b0}}, count_sat};
        since_mark_next = since_mark + {{(WordW-CountW){1'b0}}, count_sat};
        push            = accept;
        push_job.word   = {in_item.value[ByteW-1:0], {(WordW-ByteW){1'b0}}};
        push_job.nbytes = NbyteW'(1);
      end
      OP_MARK: begin
        since_mark_next = '0;
      end
      OP_QUERY: begin
        push                = accept;
        push_job.byte_valid = 1'b0;
        push_job.word       = '0;
        push_job.nbytes     = NbyteW'(1);
      end
      default: begin
        push = 1'b0;
      end
    endcase

    push_job.total = bit_total_next;
    push_job.since = since_mark_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      bit_total  <= '0;
      since_mark <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      bit_total  <= bit_total_next;
      since_mark <= since_mark_next;
    end
  end

endmodule

[sv/mbp_queue.sv]
// Small first-in first-out job queue between the front and back ends.
module mbp_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mbp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output mbp_pkg::job_t pop_job,
  output logic          empty
);
  import mbp_pkg::*;

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/mbp_back.sv]
// Back end: merges jobs with the partial byte and emits one byte per cycle while the result side is ready.
module mbp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  mbp_pkg::job_t pop_job,
  output logic          pop,
  mbp_out_if.source     result
);
  import mbp_pkg::*;

  localparam int AccW = WordW + ByteW;

  logic              busy;
  logic              is_pack;
  logic              byte_valid;
  logic [AccW-1:0]   acc;
  logic [NbyteW-1:0] remaining;
  logic [WordW-1:0]  total;
  logic [WordW-1:0]  since;
  logic [ByteW-1:0]  partial_byte;
  logic              out_valid;
  logic              emit;
  logic [ByteW-1:0]  keep;
  logic [AccW-1:0]   merged;

  assign pop  = !busy && !q_empty;
  assign emit = busy && (!out_valid || result.ready);

  always_comb begin
    keep = '0;
    if (pop_job.is_pack) begin
      keep = partial_byte & ~({ByteW{1'b1}} >> pop_job.fill);
    end
    // Raw and query jobs carry their byte in the top of the word; their fill is ignored here.
    merged = {keep, {WordW{1'b0}}} |
             ({pop_job.word, {ByteW{1'b0}}} >> (pop_job.is_pack ? pop_job.fill : '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= (pop_job.nbytes != '0);
      end else if (emit && remaining == NbyteW'(1)) begin
        busy <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_pack    <= pop_job.is_pack;
      byte_valid <= pop_job.byte_valid;
      acc        <= merged;
      remaining  <= pop_job.nbytes;
      total      <= pop_job.total;
      since      <= pop_job.since;
      // A pack job that completes no byte only refills the partial byte.
      if (pop_job.is_pack && pop_job.nbytes == '0) begin
        partial_byte <= merged[AccW-1 -: ByteW];
      end
    end else if (emit) begin
      acc       <= acc << ByteW;
      remaining <= remaining - 1'b1;
      if (is_pack && remaining == NbyteW'(1)) begin
        partial_byte <= acc[AccW-ByteW-1 -: ByteW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte        <= acc[AccW-1 -: ByteW];
      result.byte_valid      <= byte_valid;
      result.total_bits      <= total;
      result.bits_since_mark <= since;
      result.last            <= (remaining == NbyteW'(1));
    end
  end

  assign result.valid = out_valid;

endmodule

[sv/msb_first_bit_packer_unit.sv]
// MSB-first bit packer: an item is classified on transfer and, but for a mark, queued
// as a job; results leave through a registered output, one byte per cycle while the
// receiver is ready. The back end loads a job and then emits its results in turn;
// the front end keeps accepting items while the queue has room.
// Mark items need no back-end time.
// Reset (rst, synchronous) clears the counters, the fill level, the queue and the output.
module msb_first_bit_packer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  mbp_in_if.sink    in_item,
  mbp_out_if.source result
);
  import mbp_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t pop_job;

  mbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  mbp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .pop_job (pop_job),
    .pop     (pop),
    .result  (result)
  );

endmodule

[tb/msb_first_bit_packer_unit_test.sv]
// Self-checking testbench for the MSB-first bit packer: directed and random transfers.
module msb_first_bit_packer_unit_test;
  import mbp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 8;
  localparam int LongHold   = 300;
  localparam int RandomItems = 250;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic [WordW-1:0] total_bits;
    logic [WordW-1:0] bits_since_mark;
    logic             last;
  } packer_result_t;

  // Mirrors the packer state and keeps the results each accepted item still owes.
  class packer_scoreboard;
    logic [ByteW-1:0] partial;
    logic [FillW-1:0] fill;
    logic [WordW-1:0] total;
    logic [WordW-1:0] mark;
    packer_result_t   owed_results[$];
    int failures;
    int items_taken;
    int bytes_seen;
    int queries_seen;

    function new();
      partial = '0;
      fill = '0;
      total = '0;
      mark = '0;
      failures = 0;
      items_taken = 0;
      bytes_seen = 0;
      queries_seen = 0;
    endfunction

    function void absorb_item(op_t op, logic [WordW-1:0] value,
                              logic [CountW-1:0] count_in, logic [CountW-1:0] start);
      packer_result_t fresh[$];
      packer_result_t r;
      logic [CountW-1:0] count;
      int pos;
      logic bit_in;

      items_taken++;
      count = (count_in > MaxCount) ? MaxCount : count_in;
      r = '0;
      case (op)
        OP_PACK: begin
          for (int i = 0; i < int'(count); i++) begin
            pos = int'(start) - i;
            bit_in = (pos >= 0 && pos <= WordW - 1) ? value[pos] : 1'b0;
            partial[3'd7 - fill] = bit_in;
            fill = fill + 3'd1;
            // The fill level wraps to zero exactly when a byte is complete.
            if (fill == 3'd0) begin
              r.out_byte = partial;
              r.byte_valid = 1'b1;
              fresh.push_back(r);
            end
          end
          total = total + WordW'(count);
        end
        OP_RAW: begin
          r.out_byte = value[ByteW-1:0];
          r.byte_valid = 1'b1;
          fresh.push_back(r);
          total = total + WordW'(count);
        end
        OP_MARK: mark = total;
        default: begin
          r.out_byte = '0;
          r.byte_valid = 1'b0;
          fresh.push_back(r);
        end
      endcase
      foreach (fresh[k]) begin
        fresh[k].total_bits = total;
        fresh[k].bits_since_mark = total - mark;
        fresh[k].last = (k == fresh.size() - 1);
        owed_results.push_back(fresh[k]);
      end
    endfunction

    function void check_field(string field, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void compare_result(packer_result_t got);
      packer_result_t want;

      if (owed_results.size() == 0) begin
        $error("result with nothing owed: out_byte 0x%0h", got.out_byte);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      if (got.byte_valid === 1'b1) bytes_seen++;
      else queries_seen++;
      check_field("out_byte", WordW'(want.out_byte), WordW'(got.out_byte));
      check_field("byte_valid", WordW'(want.byte_valid), WordW'(got.byte_valid));
      check_field("total_bits", want.total_bits, got.total_bits);
      check_field("bits_since_mark", want.bits_since_mark, got.bits_since_mark);
      check_field("last", WordW'(want.last), WordW'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  bit   send_quiet;
  bit   take_quiet;
  bit   hold_request;

  packer_scoreboard board = new();

  mbp_in_if  in_if();
  mbp_out_if res_if();

  msb_first_bit_packer_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_if),
    .result  (res_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic [WordW-1:0] value,
                           logic [CountW-1:0] count, logic [CountW-1:0] start);
    int gap;

    gap = send_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value     <= value;
    in_if.bit_count <= count;
    in_if.start_bit <= start;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    board.absorb_item(op, value, count, start);
  endtask

  task automatic send_random_item();
    int pick;
    op_t op;
    logic [CountW-1:0] count;
    logic [CountW-1:0] start;

    pick = $urandom_range(0, 99);
    if (pick < 60) op = OP_PACK;
    else if (pick < 75) op = OP_RAW;
    else if (pick < 85) op = OP_MARK;
    else op = OP_QUERY;
    // Mostly legal counts and in-word positions, with some saturation and overreach.
    count = ($urandom_range(0, 9) == 0) ? CountW'($urandom_range(33, 63))
                                        : CountW'($urandom_range(0, 32));
    start = ($urandom_range(0, 4) == 0) ? CountW'($urandom_range(32, 63))
                                        : CountW'($urandom_range(0, 31));
    send_item(op, $urandom(), count, start);
  endtask

  // The sender stops until every owed result has come back.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Receiver: random stalls, a long hold-off when requested, checks each transfer.
  initial begin
    int stall;
    packer_result_t got;

    res_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = LongHold;
        hold_request = 1'b0;
      end else begin
        stall = take_quiet ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      got.out_byte        = res_if.out_byte;
      got.byte_valid      = res_if.byte_valid;
      got.total_bits      = res_if.total_bits;
      got.bits_since_mark = res_if.bits_since_mark;
      got.last            = res_if.last;
      board.compare_result(got);
    end
  end

  initial begin
    send_quiet = 1'b0;
    take_quiet = 1'b0;
    hold_request = 1'b0;
    rst <= 1'b1;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_PACK;
    in_if.value     <= '0;
    in_if.bit_count <= '0;
    in_if.start_bit <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: field extremes, saturation, out-of-word positions, every operation.
    send_item(OP_PACK,  32'hFFFF_FFFF, 6'd32, 6'd31);
    send_item(OP_PACK,  32'h0000_0000, 6'd8,  6'd7);
    send_item(OP_PACK,  32'hFFFF_FFFF, 6'd63, 6'd63);
    send_item(OP_PACK,  32'h0000_0001, 6'd4,  6'd0);
    send_item(OP_RAW,   32'hFFFF_FF5A, 6'd63, 6'd0);
    send_item(OP_PACK,  32'h0000_000A, 6'd4,  6'd3);
    send_item(OP_PACK,  32'h8000_0000, 6'd4,  6'd31);
    send_item(OP_QUERY, 32'hFFFF_FFFF, 6'd63, 6'd63);
    send_item(OP_MARK,  32'hFFFF_FFFF, 6'd63, 6'd63);
    send_item(OP_QUERY, 32'h0000_0000, 6'd0,  6'd0);
    send_item(OP_RAW,   32'h0000_0000, 6'd0,  6'd0);
    send_item(OP_PACK,  32'h1234_5678, 6'd0,  6'd0);
    send_item(OP_PACK,  32'hFFFF_FFFF, 6'd1,  6'd32);
    send_item(OP_PACK,  $urandom(),    6'd33, 6'd40);
    send_item(OP_PACK,  32'hFFFF_FFFF, 6'd32, 6'd0);
    send_item(OP_RAW,   32'h0000_0080, 6'd8,  6'd0);
    send_item(OP_MARK,  32'h0000_0000, 6'd0,  6'd0);
    send_item(OP_PACK,  32'hA5A5_A5A5, 6'd12, 6'd20);
    send_item(OP_QUERY, 32'h0000_0000, 6'd0,  6'd0);
    send_item(OP_PACK,  32'hFFFF_FFFF, 6'd63, 6'd0);
    send_item(OP_QUERY, 32'h0000_0000, 6'd0,  6'd0);
    wait_for_drain();

    // The receiver holds off while items keep coming, so the block backs up.
    hold_request = 1'b1;
    send_quiet = 1'b1;
    repeat (24) send_random_item();
    send_quiet = 1'b0;

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) begin
        send_quiet = ($urandom_range(0, 2) == 0);
        take_quiet = ($urandom_range(0, 2) == 0);
      end
      if (n == RandomItems / 2) wait_for_drain();
      send_random_item();
    end
    wait_for_drain();

    $display("Run covered %0d input transfers, giving %0d byte results and %0d counter reads.",
             board.items_taken, board.bytes_seen, board.queries_seen);
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
